@@ rtl/core/tpr_pkg.sv @@
package tpr_pkg;

    // item kinds
    localparam logic [1:0] KIND_PACKET   = 2'd0;
    localparam logic [1:0] KIND_ADD_PORT = 2'd1;
    localparam logic [1:0] KIND_QUERY    = 2'd2;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;

    // result codes
    localparam logic [2:0] STATUS_PASSED     = 3'd0;
    localparam logic [2:0] STATUS_REDIRECTED = 3'd1;
    localparam logic [2:0] STATUS_RESTORED   = 3'd2;
    localparam logic [2:0] STATUS_QUERY_HIT  = 3'd3;
    localparam logic [2:0] STATUS_QUERY_MISS = 3'd4;
    localparam logic [2:0] STATUS_PORT_ADDED = 3'd5;

    // register indexes
    localparam logic CFG_PROXY_MARK = 1'b0;
    localparam logic CFG_PROXY_PORT = 1'b1;

    localparam logic [31:0] PROXY_MARK_RESET = 32'd4242;
    localparam logic [15:0] PROXY_PORT_RESET = 16'd8080;
    localparam logic [15:0] ETH_IPV4         = 16'h0800;
    localparam logic [7:0]  PROTO_TCP        = 8'd6;
    localparam logic [1:0]  AGE_MAX          = 2'd3;
    localparam logic [15:0] HASH_MULT        = 16'h9E37;

    // service port bitmap, 32 bits a word
    localparam int BM_WORDS = 2048;
    localparam int BM_AW    = 11;

    // set index reduction, msb first
    localparam int MOD_BITS_PER_CYCLE = 8;
    localparam int MOD_CYCLES         = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic        from_ingress;
        logic [31:0] packet_mark;
        logic [15:0] ether_type;
        logic [7:0]  ip_protocol;
        logic        truncated;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] tcp_checksum;
        logic        query_applies;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_source_port;
        logic [15:0] out_dest_port;
        logic [15:0] out_checksum;
        logic [31:0] original_ip;
        logic [15:0] original_port;
    } rsp_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  age;
        logic [47:0] key;
        logic [47:0] value;
    } conn_entry_t;

    // ones' complement incremental update of one 16-bit word
    function automatic logic [15:0] csum_patch(logic [15:0] sum, logic [15:0] oldw,
                                               logic [15:0] neww);
        logic [17:0] a;
        logic [16:0] b;
        logic [15:0] c;
        a = {2'b00, ~sum} + {2'b00, ~oldw} + {2'b00, neww};
        b = {1'b0, a[15:0]} + {15'b0, a[17:16]};
        c = b[15:0] + {15'b0, b[16]};
        return ~c;
    endfunction

endpackage

@@ rtl/core/tpr_stream_if.sv @@
interface tpr_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/tpr_ram.sv @@
module tpr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/transparent_proxy_port_redirect.sv @@
// transparent proxy port redirect: each request beat is a parsed tcp header, a service port
// add or an original destination query, and produces exactly one response beat. after reset
// the block runs a clearing pass over the connection table and the service port bitmap and
// takes no request beat until it ends; configuration writes are taken at any time. an item
// then goes from acceptance to a registered response in order: the lookup key is hashed on
// the incoming beat, the mod steps reduce the hash modulo the number of sets (eight bits a
// cycle), and an eval step matches, updates and writes back the set row read from the
// connection memory. the eval step waits while the response register is still full. a new
// request is taken in the cycle after the write-back, so the block works on one item at a
// time. each set is one memory row holding all ways with their valid bits and lru ages.
module transparent_proxy_port_redirect #(
    parameter int CONN_ENTRIES = 16384,
    parameter int CONN_WAYS    = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    tpr_stream_if.sink   req,
    tpr_stream_if.source rsp,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int NSETS = CONN_ENTRIES / CONN_WAYS;
    localparam int SW    = $clog2(NSETS);
    localparam int RW    = SW + 1;
    localparam int ENT_W = $bits(tpr_pkg::conn_entry_t);
    localparam int ROW_W = ENT_W * CONN_WAYS;
    localparam int CLR_N = (NSETS > tpr_pkg::BM_WORDS) ? NSETS : tpr_pkg::BM_WORDS;
    localparam int CW    = $clog2(CLR_N);
    localparam int WW    = (CONN_WAYS > 1) ? $clog2(CONN_WAYS) : 1;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_MOD   = 4'b0100,
        ST_EVAL  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       clr_cnt_reg, clr_cnt_next;
    tpr_pkg::req_t       item_reg, item_next;
    logic [31:0]         hash_reg, hash_next;
    logic [SW-1:0]       rem_reg, rem_next;
    logic [1:0]          step_reg, step_next;
    logic [SW-1:0]       set_reg, set_next;
    logic                out_valid_reg, out_valid_next;
    tpr_pkg::rsp_t       out_data_reg, out_data_next;
    logic [31:0]         proxy_mark_reg;
    logic [15:0]         proxy_port_reg;

    // memory ports
    logic                conn_we;
    logic [SW-1:0]       conn_waddr, conn_raddr;
    logic [ROW_W-1:0]    conn_wdata, conn_rdata;
    logic                bm_we;
    logic [tpr_pkg::BM_AW-1:0] bm_waddr, bm_raddr;
    logic [31:0]         bm_wdata, bm_rdata;

    tpr_ram #(.WIDTH(ROW_W), .DEPTH(NSETS)) u_conn_ram (
        .clk   (clk),
        .we    (conn_we),
        .waddr (conn_waddr),
        .wdata (conn_wdata),
        .raddr (conn_raddr),
        .rdata (conn_rdata)
    );

    tpr_ram #(.WIDTH(32), .DEPTH(tpr_pkg::BM_WORDS)) u_bitmap_ram (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    // handshake
    logic accept;
    logic fire;
    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    // response slot free: eval completes only then, so the write-back happens once
    assign fire      = (state_reg == ST_EVAL) && (!out_valid_reg || rsp.ready);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // key hash on the incoming beat: ingress packets key on the client side
    logic [31:0] h_ip;
    logic [15:0] h_port;
    logic [31:0] h_prod;
    logic [31:0] h_val;
    always_comb
    begin
        if (req.data.kind == tpr_pkg::KIND_PACKET && req.data.from_ingress)
        begin
            h_ip   = req.data.source_ip;
            h_port = req.data.source_port;
        end
        else
        begin
            h_ip   = req.data.dest_ip;
            h_port = req.data.dest_port;
        end
        h_prod = {16'b0, h_port} * {16'b0, tpr_pkg::HASH_MULT};
        h_val  = h_ip ^ (h_ip >> 13) ^ (h_ip >> 23) ^ h_prod ^ ({16'b0, h_port} >> 5);
    end

    // one slice of the restoring modulo reduction
    logic [RW-1:0] mod_r;
    logic [SW-1:0] rem_step;
    always_comb
    begin
        mod_r = {1'b0, rem_reg};
        for (int i = 0; i < tpr_pkg::MOD_BITS_PER_CYCLE; i++)
        begin
            mod_r = {mod_r[SW-1:0], hash_reg[31-i]};
            if (mod_r >= RW'(NSETS))
            begin
                mod_r = mod_r - RW'(NSETS);
            end
        end
        rem_step = mod_r[SW-1:0];
    end

    // set row evaluation
    tpr_pkg::conn_entry_t ent     [CONN_WAYS];
    tpr_pkg::conn_entry_t ent_new [CONN_WAYS];
    logic [47:0]   key_lk, key_ins;
    logic          eligible, do_insert, do_egress, do_query, lk_req;
    logic          lk_hit, ins_hit, ins_free;
    logic [WW-1:0] lk_way, ins_way, pick_way, touch_way, best_way;
    logic [1:0]    best_age;
    logic [47:0]   lk_value;
    logic          port_listed;
    logic          row_write;
    tpr_pkg::rsp_t eval_rsp;

    always_comb
    begin
        for (int w = 0; w < CONN_WAYS; w++)
        begin
            ent[w] = conn_rdata[w*ENT_W +: ENT_W];
        end

        key_lk  = {item_reg.dest_ip, item_reg.dest_port};
        key_ins = {item_reg.source_ip, item_reg.source_port};

        eligible = (item_reg.kind == tpr_pkg::KIND_PACKET)
                && (item_reg.packet_mark != proxy_mark_reg)
                && (item_reg.ether_type == tpr_pkg::ETH_IPV4)
                && (item_reg.ip_protocol == tpr_pkg::PROTO_TCP)
                && !item_reg.truncated;
        port_listed = bm_rdata[item_reg.dest_port[4:0]];
        do_insert = eligible && item_reg.from_ingress && port_listed;
        do_egress = eligible && !item_reg.from_ingress
                && (item_reg.source_port == proxy_port_reg);
        do_query  = (item_reg.kind == tpr_pkg::KIND_QUERY) && item_reg.query_applies;
        lk_req    = do_egress || do_query;

        // first matching way for lookup and for insert
        lk_hit   = 1'b0;
        lk_way   = '0;
        ins_hit  = 1'b0;
        ins_way  = '0;
        ins_free = 1'b0;
        pick_way = '0;
        for (int w = 0; w < CONN_WAYS; w++)
        begin
            if (!lk_hit && ent[w].valid && ent[w].key == key_lk)
            begin
                lk_hit = 1'b1;
                lk_way = WW'(w);
            end
            if (!ins_hit && ent[w].valid && ent[w].key == key_ins)
            begin
                ins_hit = 1'b1;
                ins_way = WW'(w);
            end
            if (!ins_free && !ent[w].valid)
            begin
                ins_free = 1'b1;
                pick_way = WW'(w);
            end
        end
        lk_value = ent[lk_way].value;

        // lowest way with the largest age
        best_way = '0;
        best_age = ent[0].age;
        for (int w = 1; w < CONN_WAYS; w++)
        begin
            if (ent[w].age > best_age)
            begin
                best_way = WW'(w);
                best_age = ent[w].age;
            end
        end

        priority if (ins_hit)
        begin
            pick_way = ins_way;
        end
        else if (!ins_free)
        begin
            pick_way = best_way;
        end
        else
        begin
            pick_way = pick_way;
        end

        touch_way = do_insert ? pick_way : lk_way;
        row_write = do_insert || (lk_req && lk_hit);

        for (int w = 0; w < CONN_WAYS; w++)
        begin
            ent_new[w] = ent[w];
            if (WW'(w) == touch_way)
            begin
                ent_new[w].age = 2'd0;
                if (do_insert)
                begin
                    ent_new[w].valid = 1'b1;
                    ent_new[w].key   = key_ins;
                    ent_new[w].value = key_lk;
                end
            end
            else if (ent[w].valid && ent[w].age < tpr_pkg::AGE_MAX)
            begin
                ent_new[w].age = ent[w].age + 2'd1;
            end
        end

        eval_rsp.status          = tpr_pkg::STATUS_PASSED;
        eval_rsp.out_source_port = item_reg.source_port;
        eval_rsp.out_dest_port   = item_reg.dest_port;
        eval_rsp.out_checksum    = item_reg.tcp_checksum;
        eval_rsp.original_ip     = '0;
        eval_rsp.original_port   = '0;
        priority if (item_reg.kind == tpr_pkg::KIND_ADD_PORT)
        begin
            eval_rsp.status = tpr_pkg::STATUS_PORT_ADDED;
        end
        else if (item_reg.kind == tpr_pkg::KIND_QUERY)
        begin
            eval_rsp.status = tpr_pkg::STATUS_QUERY_MISS;
            if (do_query && lk_hit)
            begin
                eval_rsp.status        = tpr_pkg::STATUS_QUERY_HIT;
                eval_rsp.original_ip   = lk_value[47:16];
                eval_rsp.original_port = lk_value[15:0];
            end
        end
        else if (do_insert)
        begin
            eval_rsp.status        = tpr_pkg::STATUS_REDIRECTED;
            eval_rsp.out_dest_port = proxy_port_reg;
            eval_rsp.out_checksum  = tpr_pkg::csum_patch(item_reg.tcp_checksum,
                                                         item_reg.dest_port, proxy_port_reg);
        end
        else if (do_egress && lk_hit)
        begin
            eval_rsp.status          = tpr_pkg::STATUS_RESTORED;
            eval_rsp.out_source_port = lk_value[15:0];
            eval_rsp.out_checksum    = tpr_pkg::csum_patch(item_reg.tcp_checksum,
                                                           item_reg.source_port,
                                                           lk_value[15:0]);
        end
        else
        begin
            eval_rsp.status = tpr_pkg::STATUS_PASSED;
        end
    end

    // memory port muxing: clearing pass, else eval write-back
    // writes land only at eval, before the next item reads its set row: no overlap
    logic clr_conn, clr_bm;
    assign clr_conn = (state_reg == ST_CLEAR) && ({1'b0, clr_cnt_reg} < (CW+1)'(NSETS));
    assign clr_bm   = (state_reg == ST_CLEAR)
                   && ({1'b0, clr_cnt_reg} < (CW+1)'(tpr_pkg::BM_WORDS));

    always_comb
    begin
        for (int w = 0; w < CONN_WAYS; w++)
        begin
            conn_wdata[w*ENT_W +: ENT_W] = clr_conn ? '0 : ent_new[w];
        end
    end
    assign conn_we    = clr_conn || (fire && row_write);
    assign conn_waddr = clr_conn ? clr_cnt_reg[SW-1:0] : set_reg;
    assign conn_raddr = (state_reg == ST_MOD) ? rem_step : set_reg;

    assign bm_we    = clr_bm || (fire && item_reg.kind == tpr_pkg::KIND_ADD_PORT);
    assign bm_waddr = clr_bm ? clr_cnt_reg[tpr_pkg::BM_AW-1:0] : item_reg.dest_port[15:5];
    assign bm_wdata = clr_bm ? 32'd0 : (bm_rdata | (32'd1 << item_reg.dest_port[4:0]));
    assign bm_raddr = item_reg.dest_port[15:5];

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        item_next      = item_reg;
        hash_next      = hash_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        set_next       = set_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + CW'(1);
                if (clr_cnt_reg == CW'(CLR_N - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next  = req.data;
                    hash_next  = h_val;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                hash_next = hash_reg << tpr_pkg::MOD_BITS_PER_CYCLE;
                rem_next  = rem_step;
                step_next = step_reg + 2'd1;
                if (step_reg == 2'(tpr_pkg::MOD_CYCLES - 1))
                begin
                    set_next   = rem_step;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (fire)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = eval_rsp;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        hash_reg     <= hash_next;
        rem_reg      <= rem_next;
        set_reg      <= set_next;
        out_data_reg <= out_data_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proxy_mark_reg <= tpr_pkg::PROXY_MARK_RESET;
            proxy_port_reg <= tpr_pkg::PROXY_PORT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tpr_pkg::CFG_PROXY_MARK: proxy_mark_reg <= cfg_data;
                tpr_pkg::CFG_PROXY_PORT: proxy_port_reg <= cfg_data[15:0];
                default:                 proxy_mark_reg <= proxy_mark_reg;
            endcase
        end
    end

    // no request beat is taken during the clearing pass
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !req.ready)
        else $error("request taken during clearing pass");

    // a response appears only out of the eval step
    a_rsp_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EVAL))
        else $error("response without eval");

    // connection writes only from clearing or an eval that completes
    a_conn_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        conn_we |-> (state_reg == ST_CLEAR) || fire)
        else $error("stray connection table write");

    // the set index stays inside the table
    a_set_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL) |-> ({1'b0, set_reg} < RW'(NSETS)))
        else $error("set index out of range");

endmodule

@@ sim/transparent_proxy_port_redirect_tb.sv @@
module transparent_proxy_port_redirect_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SETS = 16384 / 4;
    localparam int NUM_WAYS = 4;
    localparam int IDLE_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;

    tpr_stream_if #(.T(tpr_pkg::req_t)) req ();
    tpr_stream_if #(.T(tpr_pkg::rsp_t)) rsp ();

    transparent_proxy_port_redirect uut (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // predictor state: registers, port bitmap, connection table
    logic [31:0] mark_reg;
    logic [15:0] port_reg;
    bit          port_listed [65536];
    bit          tbl_valid [NUM_SETS][NUM_WAYS];
    logic [1:0]  tbl_age [NUM_SETS][NUM_WAYS];
    logic [47:0] tbl_key [NUM_SETS][NUM_WAYS];
    logic [47:0] tbl_val [NUM_SETS][NUM_WAYS];

    tpr_pkg::req_t pending_beats [$];
    tpr_pkg::rsp_t expected_rsps [$];
    int   errors = 0;
    int   beats_sent = 0;
    int   beats_checked = 0;
    int   idle_cycles = 0;
    int   send_gap = 0;
    int   recv_gap = 0;
    int   redirect_seen = 0;
    int   restore_seen = 0;
    int   qhit_seen = 0;

    // known clients so packets and queries find table entries
    logic [31:0] client_ip [$];
    logic [15:0] client_port [$];
    logic [15:0] svc_ports [$];

    function automatic int hash_set(logic [47:0] key);
        logic [31:0] ip;
        logic [31:0] p;
        logic [31:0] h;
        ip = key[47:16];
        p  = {16'b0, key[15:0]};
        h  = ip ^ (ip >> 13) ^ (ip >> 23) ^ (p * 32'h9E37) ^ (p >> 5);
        return int'(h % NUM_SETS);
    endfunction

    function automatic void age_set(int s, int way);
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (w == way)
                tbl_age[s][w] = 2'd0;
            else if (tbl_valid[s][w] && tbl_age[s][w] < tpr_pkg::AGE_MAX)
                tbl_age[s][w] = tbl_age[s][w] + 2'd1;
        end
    endfunction

    function automatic bit table_find(logic [47:0] key, output logic [47:0] val);
        int s;
        s = hash_set(key);
        val = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (tbl_valid[s][w] && tbl_key[s][w] == key)
            begin
                val = tbl_val[s][w];
                age_set(s, w);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void table_store(logic [47:0] key, logic [47:0] val);
        int s;
        int pick;
        s = hash_set(key);
        pick = -1;
        for (int w = 0; w < NUM_WAYS && pick < 0; w++)
            if (tbl_valid[s][w] && tbl_key[s][w] == key)
                pick = w;
        for (int w = 0; w < NUM_WAYS && pick < 0; w++)
            if (!tbl_valid[s][w])
                pick = w;
        if (pick < 0)
        begin
            pick = 0;
            for (int w = 1; w < NUM_WAYS; w++)
                if (tbl_age[s][w] > tbl_age[s][pick])
                    pick = w;
        end
        tbl_key[s][pick] = key;
        tbl_val[s][pick] = val;
        tbl_valid[s][pick] = 1'b1;
        age_set(s, pick);
    endfunction

    function automatic logic [15:0] csum_fix(logic [15:0] sum, logic [15:0] oldw,
                                             logic [15:0] neww);
        logic [31:0] a;
        a = {16'b0, ~sum} + {16'b0, ~oldw} + {16'b0, neww};
        a = (a & 32'hFFFF) + (a >> 16);
        a = (a & 32'hFFFF) + (a >> 16);
        return ~a[15:0];
    endfunction

    // expected response for one accepted request beat
    function automatic tpr_pkg::rsp_t redirect_predict(tpr_pkg::req_t r);
        tpr_pkg::rsp_t o;
        logic [47:0] v;
        o.status = tpr_pkg::STATUS_PASSED;
        o.out_source_port = r.source_port;
        o.out_dest_port = r.dest_port;
        o.out_checksum = r.tcp_checksum;
        o.original_ip = '0;
        o.original_port = '0;
        if (r.kind == tpr_pkg::KIND_ADD_PORT)
        begin
            port_listed[r.dest_port] = 1'b1;
            o.status = tpr_pkg::STATUS_PORT_ADDED;
        end
        else if (r.kind == tpr_pkg::KIND_QUERY)
        begin
            o.status = tpr_pkg::STATUS_QUERY_MISS;
            if (r.query_applies && table_find({r.dest_ip, r.dest_port}, v))
            begin
                o.status = tpr_pkg::STATUS_QUERY_HIT;
                o.original_ip = v[47:16];
                o.original_port = v[15:0];
            end
        end
        else if (r.kind == tpr_pkg::KIND_PACKET && r.packet_mark != mark_reg &&
                 r.ether_type == tpr_pkg::ETH_IPV4 && r.ip_protocol == tpr_pkg::PROTO_TCP &&
                 !r.truncated)
        begin
            if (r.from_ingress)
            begin
                if (port_listed[r.dest_port])
                begin
                    table_store({r.source_ip, r.source_port}, {r.dest_ip, r.dest_port});
                    o.out_dest_port = port_reg;
                    o.out_checksum = csum_fix(r.tcp_checksum, r.dest_port, port_reg);
                    o.status = tpr_pkg::STATUS_REDIRECTED;
                end
            end
            else if (r.source_port == port_reg)
            begin
                if (table_find({r.dest_ip, r.dest_port}, v))
                begin
                    o.out_source_port = v[15:0];
                    o.out_checksum = csum_fix(r.tcp_checksum, r.source_port, v[15:0]);
                    o.status = tpr_pkg::STATUS_RESTORED;
                end
            end
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        $display("mismatch %s: got %0h want %0h (beat %0d)", what, got, want, beats_checked);
        errors++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // driver: one beat from the pending queue whenever the gap has run out
    always @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            expected_rsps.push_back(redirect_predict(req.data));
            beats_sent++;
            void'(pending_beats.pop_front());
            send_gap <= pick_gap();
            if (pending_beats.size() > 0 && pick_gap() == 0)
                req.data <= pending_beats[0];
            else
                req.valid <= 1'b0;
        end
        else if (!req.valid)
        begin
            if (send_gap > 0)
                send_gap <= send_gap - 1;
            else if (pending_beats.size() > 0)
            begin
                req.valid <= 1'b1;
                req.data <= pending_beats[0];
            end
        end
    end

    // monitor: random backpressure, compare each response beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rsp.valid && rsp.ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                $display("unexpected response beat");
                errors++;
            end
            else
            begin
                tpr_pkg::rsp_t e;
                e = expected_rsps.pop_front();
                if (rsp.data.status != e.status)
                    report_mismatch("status", 48'(rsp.data.status), 48'(e.status));
                if (rsp.data.out_source_port != e.out_source_port)
                    report_mismatch("out_source_port", 48'(rsp.data.out_source_port),
                                    48'(e.out_source_port));
                if (rsp.data.out_dest_port != e.out_dest_port)
                    report_mismatch("out_dest_port", 48'(rsp.data.out_dest_port),
                                    48'(e.out_dest_port));
                if (rsp.data.out_checksum != e.out_checksum)
                    report_mismatch("out_checksum", 48'(rsp.data.out_checksum),
                                    48'(e.out_checksum));
                if (rsp.data.original_ip != e.original_ip)
                    report_mismatch("original_ip", 48'(rsp.data.original_ip),
                                    48'(e.original_ip));
                if (rsp.data.original_port != e.original_port)
                    report_mismatch("original_port", 48'(rsp.data.original_port),
                                    48'(e.original_port));
                if (e.status == tpr_pkg::STATUS_REDIRECTED) redirect_seen++;
                if (e.status == tpr_pkg::STATUS_RESTORED) restore_seen++;
                if (e.status == tpr_pkg::STATUS_QUERY_HIT) qhit_seen++;
            end
            beats_checked++;
        end
        if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            rsp.ready <= 1'b0;
        end
        else
        begin
            rsp.ready <= 1'b1;
            if (rsp.valid && rsp.ready)
                recv_gap <= pick_gap();
        end
    end

    // watchdog on cycles without any accepted beat while work is outstanding
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
            (pending_beats.size() == 0 && expected_rsps.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic tpr_pkg::req_t base_packet();
        tpr_pkg::req_t r;
        r.kind = tpr_pkg::KIND_PACKET;
        r.from_ingress = 1'($urandom_range(0, 1));
        r.packet_mark = $urandom();
        r.ether_type = tpr_pkg::ETH_IPV4;
        r.ip_protocol = tpr_pkg::PROTO_TCP;
        r.truncated = 1'b0;
        r.source_ip = $urandom();
        r.dest_ip = $urandom();
        r.source_port = 16'($urandom());
        r.dest_port = 16'($urandom());
        r.tcp_checksum = 16'($urandom());
        r.query_applies = 1'($urandom_range(0, 1));
        if (r.packet_mark == mark_reg)
            r.packet_mark = ~r.packet_mark;
        return r;
    endfunction

    // a random beat, mostly well formed traffic around known clients and service ports
    function automatic tpr_pkg::req_t random_beat();
        tpr_pkg::req_t r;
        int pick;
        int c;
        r = base_packet();
        pick = $urandom_range(0, 99);
        if (pick < 8 || svc_ports.size() == 0)
        begin
            r.kind = tpr_pkg::KIND_ADD_PORT;
            if ($urandom_range(0, 3) == 0)
                r.dest_port = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            svc_ports.push_back(r.dest_port);
        end
        else if (pick < 40)
        begin
            // client to service port, small client pool keeps sets busy
            r.from_ingress = 1'b1;
            r.dest_port = svc_ports[$urandom_range(0, svc_ports.size() - 1)];
            if (client_ip.size() > 0 && $urandom_range(0, 2) == 0)
            begin
                c = $urandom_range(0, client_ip.size() - 1);
                r.source_ip = client_ip[c];
                r.source_port = client_port[c];
            end
            else if (client_ip.size() < 300)
            begin
                client_ip.push_back(r.source_ip);
                client_port.push_back(r.source_port);
            end
        end
        else if (pick < 65 && client_ip.size() > 0)
        begin
            // proxy reply back to the client
            c = $urandom_range(0, client_ip.size() - 1);
            r.from_ingress = 1'b0;
            r.source_port = port_reg;
            r.dest_ip = client_ip[c];
            r.dest_port = client_port[c];
        end
        else if (pick < 85 && client_ip.size() > 0)
        begin
            c = $urandom_range(0, client_ip.size() - 1);
            r.kind = tpr_pkg::KIND_QUERY;
            r.query_applies = ($urandom_range(0, 5) != 0);
            if ($urandom_range(0, 4) != 0)
            begin
                r.dest_ip = client_ip[c];
                r.dest_port = client_port[c];
            end
        end
        else
        begin
            // noise: failed pass tests, unused kind, raw random fields
            case ($urandom_range(0, 5))
                0: r.packet_mark = mark_reg;
                1: r.ether_type = 16'($urandom());
                2: r.ip_protocol = 8'($urandom());
                3: r.truncated = 1'b1;
                4: r.kind = tpr_pkg::KIND_UNUSED;
                default: r.kind = 2'($urandom_range(0, 3));
            endcase
            if ($urandom_range(0, 1))
                r.dest_port = svc_ports[$urandom_range(0, svc_ports.size() - 1)];
        end
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_beats.size() > 0 || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == tpr_pkg::CFG_PROXY_MARK)
            mark_reg = val;
        else
            port_reg = val[15:0];
        @(posedge clk);
    endtask

    initial
    begin
        tpr_pkg::req_t r;
        logic [31:0] marks [4];
        logic [15:0] ports [4];
        req.valid = 1'b0;
        req.data = '0;
        rsp.ready = 1'b0;
        mark_reg = tpr_pkg::PROXY_MARK_RESET;
        port_reg = tpr_pkg::PROXY_PORT_RESET;
        marks = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, tpr_pkg::PROXY_MARK_RESET};
        ports = '{16'hFFFF, 16'h0000, 16'd3128, tpr_pkg::PROXY_PORT_RESET};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: port adds at the extremes, redirect, restore, queries, pass cases
        r = base_packet(); r.kind = tpr_pkg::KIND_ADD_PORT; r.dest_port = 16'd80;
        pending_beats.push_back(r); svc_ports.push_back(16'd80);
        r.dest_port = 16'hFFFF; pending_beats.push_back(r); svc_ports.push_back(16'hFFFF);
        r.dest_port = 16'h0000; pending_beats.push_back(r); svc_ports.push_back(16'h0000);
        r = base_packet(); r.from_ingress = 1'b1; r.dest_port = 16'd80;
        r.source_ip = 32'hFFFF_FFFF; r.source_port = 16'hFFFF; r.tcp_checksum = 16'hFFFF;
        pending_beats.push_back(r);
        client_ip.push_back(r.source_ip); client_port.push_back(r.source_port);
        r = base_packet(); r.from_ingress = 1'b0; r.source_port = port_reg;
        r.dest_ip = 32'hFFFF_FFFF; r.dest_port = 16'hFFFF; r.tcp_checksum = 16'h0000;
        pending_beats.push_back(r);
        r.kind = tpr_pkg::KIND_QUERY; r.query_applies = 1'b1; pending_beats.push_back(r);
        r.query_applies = 1'b0; pending_beats.push_back(r);
        r.query_applies = 1'b1; r.dest_port = 16'h1; pending_beats.push_back(r);
        r = base_packet(); r.from_ingress = 1'b1; r.dest_port = 16'd80;
        r.packet_mark = mark_reg; pending_beats.push_back(r);
        r = base_packet(); r.from_ingress = 1'b1; r.dest_port = 16'd80;
        r.ether_type = 16'h86DD; pending_beats.push_back(r);
        r.ether_type = tpr_pkg::ETH_IPV4; r.ip_protocol = 8'd17; pending_beats.push_back(r);
        r.ip_protocol = tpr_pkg::PROTO_TCP; r.truncated = 1'b1; pending_beats.push_back(r);
        r.truncated = 1'b0; r.dest_port = 16'd81; pending_beats.push_back(r);
        r = base_packet(); r.kind = tpr_pkg::KIND_UNUSED; pending_beats.push_back(r);
        r = base_packet(); r.from_ingress = 1'b0; r.source_port = port_reg + 16'd1;
        pending_beats.push_back(r);
        r = base_packet(); r.from_ingress = 1'b0; r.source_port = port_reg;
        pending_beats.push_back(r);
        // fill one set past its ways to force lru eviction: same client ip, ports that
        // map to one set are found by search
        begin
            int target;
            int found;
            logic [15:0] p;
            target = hash_set({32'hC0A8_0001, 16'd1000});
            found = 0;
            p = 16'd1000;
            while (found < 6)
            begin
                if (hash_set({32'hC0A8_0001, p}) == target)
                begin
                    r = base_packet(); r.from_ingress = 1'b1; r.dest_port = 16'hFFFF;
                    r.source_ip = 32'hC0A8_0001; r.source_port = p;
                    pending_beats.push_back(r);
                    client_ip.push_back(r.source_ip); client_port.push_back(p);
                    found++;
                end
                p++;
            end
        end
        wait_drained();

        // random phases under several register settings
        for (int ph = 0; ph < 4; ph++)
        begin
            write_cfg(tpr_pkg::CFG_PROXY_MARK, marks[ph]);
            write_cfg(tpr_pkg::CFG_PROXY_PORT, {16'b0, ports[ph]});
            for (int i = 0; i < 260; i++)
                pending_beats.push_back(random_beat());
            wait_drained();
        end

        $display("checked %0d response beats of %0d sent over 4 register settings",
                 beats_checked, beats_sent);
        $display("redirects %0d, restores %0d, query hits %0d",
                 redirect_seen, restore_seen, qhit_seen);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
